// ----- design/packet_jitter_buffer_controller_core_macros.svh -----
// assertion macros for the jitter buffer controller
// expects clk_i and rst_ni in the including module's scope
`ifndef PACKET_JITTER_BUFFER_CONTROLLER_CORE_MACROS_SVH
`define PACKET_JITTER_BUFFER_CONTROLLER_CORE_MACROS_SVH

// same-cycle implication
`define PJBC_ASSERT_NOW(name, ante, cons, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define PJBC_ASSERT_NEXT(name, ante, cons, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- design/pjbc_pkg.sv -----
// shared types, codes and constants of the jitter buffer controller
// no dependencies
`default_nettype none

package pjbc_pkg;

  localparam int PJBC_SLOTS       = 128;
  localparam int PJBC_FRAME_LEN   = 960;
  localparam int PJBC_MAX_PAYLOAD = 512;

  localparam logic [7:0]  RST_START_FILL      = 8'd50;
  localparam logic [7:0]  RST_RESUME_FILL     = 8'd40;
  localparam logic [7:0]  RST_LOW_WATER       = 8'd12;
  localparam logic [7:0]  RST_MISS_LIMIT      = 8'd10;
  localparam logic [15:0] RST_AHEAD_WINDOW    = 16'd220;
  localparam logic [15:0] RST_HARD_GAP        = 16'd170;
  localparam logic [7:0]  RST_HARD_MISS_LIMIT = 8'd24;
  localparam logic [15:0] RST_IDLE_TIMEOUT    = 16'd1800;

  localparam logic [31:0] SEQ_MAX = 32'hFFFF_FFFF;
  localparam logic [7:0]  MISS_MAX = 8'd255;

  typedef enum logic [1:0] {
    OP_ARRIVAL = 2'd0,
    OP_TICK    = 2'd1,
    OP_END     = 2'd2,
    OP_RESET   = 2'd3
  } opcode_e;

  typedef enum logic [3:0] {
    STAT_INSERTED  = 4'd0,
    STAT_MALFORMED = 4'd1,
    STAT_DUPLICATE = 4'd2,
    STAT_LATE      = 4'd3,
    STAT_BEYOND    = 4'd4,
    STAT_FULL      = 4'd5,
    STAT_WAITING   = 4'd6,
    STAT_PLAY      = 4'd7,
    STAT_CONCEAL   = 4'd8,
    STAT_REBUFFER  = 4'd9,
    STAT_END_FIN   = 4'd10,
    STAT_TIMEOUT   = 4'd11,
    STAT_END_REC   = 4'd12,
    STAT_RESET     = 4'd13
  } status_e;

  typedef enum logic [2:0] {
    CFG_START_FILL      = 3'd0,
    CFG_RESUME_FILL     = 3'd1,
    CFG_LOW_WATER       = 3'd2,
    CFG_MISS_LIMIT      = 3'd3,
    CFG_AHEAD_WINDOW    = 3'd4,
    CFG_HARD_GAP        = 3'd5,
    CFG_HARD_MISS_LIMIT = 3'd6,
    CFG_IDLE_TIMEOUT    = 3'd7
  } cfg_e;

  typedef enum logic [1:0] {
    ST_IDLE   = 2'd0,
    ST_SCAN   = 2'd1,
    ST_DECIDE = 2'd2,
    ST_OUT    = 2'd3
  } state_e;

  typedef struct packed {
    opcode_e     opcode;
    logic [31:0] sequence_req;
    logic [15:0] frame_samples;
    logic [15:0] payload_len;
    logic        payload_present;
    logic [31:0] now_ms;
  } in_req_t;

  typedef struct packed {
    status_e     status;
    logic [6:0]  slot_index;
    logic [31:0] play_sequence;
    logic        fec_present;
    logic [6:0]  fec_slot;
    logic [7:0]  buffered_count;
    logic        hard_rebuffer;
  } out_res_t;

  // scan flags handed from the scan unit to the sequencer
  typedef struct packed {
    logic done;
    logic key_hit;
    logic next_hit;
    logic free_hit;
  } scan_flags_t;

endpackage

`default_nettype wire

// ----- design/pjbc_scan.sv -----
// slot scan unit: sequence memory plus one-slot-per-cycle search pipeline
// depends on pjbc_pkg
`default_nettype none

module pjbc_scan import pjbc_pkg::*; #(
  parameter int SLOTS = PJBC_SLOTS,
  localparam int IW = (SLOTS > 1) ? $clog2(SLOTS) : 1,
  localparam int CW = $clog2(SLOTS + 1)
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start_i,
  input  logic [32:0]      key_i,
  input  logic [32:0]      next_key_i,
  input  logic [SLOTS-1:0] used_i,
  input  logic             wr_en_i,
  input  logic [IW-1:0]    wr_idx_i,
  input  logic [31:0]      wr_data_i,
  output scan_flags_t      flags_o,
  output logic [CW-1:0]    count_o,
  output logic [31:0]      min_o,
  output logic [IW-1:0]    key_idx_o,
  output logic [IW-1:0]    next_idx_o,
  output logic [IW-1:0]    free_idx_o
);

  logic [31:0]   mem [SLOTS];
  logic [31:0]   rdata_q;
  logic [IW:0]   addr_q;
  logic          active_q;
  logic          p_vld_q;
  logic          p_used_q;
  logic [IW-1:0] p_idx_q;
  logic [32:0]   key_q, next_key_q;
  logic          key_hit_q, next_hit_q, free_hit_q;
  logic [IW-1:0] key_idx_q, next_idx_q, free_idx_q;
  logic [CW-1:0] count_q;
  logic [31:0]   min_q;
  logic          issue;
  logic          done;

  assign issue = active_q && (addr_q < (IW+1)'(SLOTS));
  assign done  = active_q && !issue && !p_vld_q;

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem[wr_idx_i] <= wr_data_i;
    end
    rdata_q <= mem[addr_q[IW-1:0]];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      active_q   <= 1'b0;
      addr_q     <= '0;
      p_vld_q    <= 1'b0;
      p_used_q   <= 1'b0;
      p_idx_q    <= '0;
      key_q      <= '0;
      next_key_q <= '0;
      key_hit_q  <= 1'b0;
      next_hit_q <= 1'b0;
      free_hit_q <= 1'b0;
      key_idx_q  <= '0;
      next_idx_q <= '0;
      free_idx_q <= '0;
      count_q    <= '0;
      min_q      <= SEQ_MAX;
    end else if (start_i) begin
      active_q   <= 1'b1;
      addr_q     <= '0;
      p_vld_q    <= 1'b0;
      key_q      <= key_i;
      next_key_q <= next_key_i;
      key_hit_q  <= 1'b0;
      next_hit_q <= 1'b0;
      free_hit_q <= 1'b0;
      count_q    <= '0;
      min_q      <= SEQ_MAX;
    end else begin
      if (done) begin
        active_q <= 1'b0;
      end
      p_vld_q <= issue;
      if (issue) begin
        p_idx_q  <= addr_q[IW-1:0];
        p_used_q <= used_i[addr_q[IW-1:0]];
        addr_q   <= addr_q + 1'b1;
      end
      // compare stage, lowest index wins
      if (p_vld_q) begin
        if (p_used_q) begin
          count_q <= count_q + 1'b1;
          if (rdata_q < min_q) begin
            min_q <= rdata_q;
          end
          if (!key_hit_q && ({1'b0, rdata_q} == key_q)) begin
            key_hit_q <= 1'b1;
            key_idx_q <= p_idx_q;
          end
          if (!next_hit_q && ({1'b0, rdata_q} == next_key_q)) begin
            next_hit_q <= 1'b1;
            next_idx_q <= p_idx_q;
          end
        end else if (!free_hit_q) begin
          free_hit_q <= 1'b1;
          free_idx_q <= p_idx_q;
        end
      end
    end
  end

  assign flags_o.done     = done;
  assign flags_o.key_hit  = key_hit_q;
  assign flags_o.next_hit = next_hit_q;
  assign flags_o.free_hit = free_hit_q;
  assign count_o    = count_q;
  assign min_o      = min_q;
  assign key_idx_o  = key_idx_q;
  assign next_idx_o = next_idx_q;
  assign free_idx_o = free_idx_q;

endmodule

`default_nettype wire

// ----- design/packet_jitter_buffer_controller_core.sv -----
// jitter buffer controller top level: sequencer, session state, config, result register
// depends on pjbc_pkg, pjbc_scan and the assertion macro header
//
// channel | direction | signals                       | content
// in      | request   | in_valid_i/in_ready_o/in_i    | arrival, tick, end mark, reset
// out     | result    | out_valid_o/out_ready_i/out_o | one result per request
// cfg     | write     | cfg_we_i/cfg_idx_i/cfg_data_i | eight tuning registers
//
// a request makes one scan pass, or two when a tick starts or resumes playback:
// the scan unit reads one slot of the sequence memory per cycle
// reset clears all slots at once through the per-slot used bits, no sweep
// in_ready_o is high only when the sequencer is idle; a finished result waits in the
// output register, and a new request is taken while it waits
`default_nettype none

module packet_jitter_buffer_controller_core import pjbc_pkg::*; #(
  parameter int SLOTS       = PJBC_SLOTS,
  parameter int FRAME_LEN   = PJBC_FRAME_LEN,
  parameter int MAX_PAYLOAD = PJBC_MAX_PAYLOAD
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  in_req_t     in_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output out_res_t    out_o,
  input  logic        cfg_we_i,
  input  logic [2:0]  cfg_idx_i,
  input  logic [15:0] cfg_data_i
);

`include "packet_jitter_buffer_controller_core_macros.svh"

  localparam int IW  = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam int CW  = $clog2(SLOTS + 1);
  localparam int CMW = (CW > 9) ? CW : 9;

  // config registers
  logic [7:0]  start_fill_q, resume_fill_q, low_water_q, miss_limit_q, hard_miss_q;
  logic [15:0] ahead_q, hard_gap_q, idle_to_q;

  // session state
  logic [SLOTS-1:0] used_q, used_d;
  logic        playing_q, playing_d;
  logic        rebuf_q, rebuf_d;
  logic        end_seen_q, end_seen_d;
  logic        finished_q, finished_d;
  logic        any_rx_q, any_rx_d;
  logic [31:0] exp_q, exp_d;
  logic [31:0] highest_q, highest_d;
  logic [31:0] final_q, final_d;
  logic [7:0]  miss_q, miss_d;
  logic [31:0] last_arr_q, last_arr_d;

  // per-request context
  state_e      state_q, state_d;
  in_req_t     req_q;
  logic        pass_q;
  logic [8:0]  miss1_q;
  logic [31:0] old_exp_q;
  out_res_t    res_q, res_d;
  out_res_t    out_q;
  logic        out_vld_q;

  // scan unit hookup
  scan_flags_t   flags;
  logic [CW-1:0] cnt;
  logic [31:0]   min_seq;
  logic [IW-1:0] key_idx, next_idx, free_idx;
  logic          scan_start;
  logic [32:0]   scan_key, scan_next_key;
  logic          wr_en;
  logic          rescan;
  logic          res_load;
  logic          accept;

  assign accept = in_valid_i && in_ready_o;

  pjbc_scan #(.SLOTS(SLOTS)) u_scan (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (scan_start),
    .key_i      (scan_key),
    .next_key_i (scan_next_key),
    .used_i     (used_q),
    .wr_en_i    (wr_en),
    .wr_idx_i   (free_idx),
    .wr_data_i  (req_q.sequence_req),
    .flags_o    (flags),
    .count_o    (cnt),
    .min_o      (min_seq),
    .key_idx_o  (key_idx),
    .next_idx_o (next_idx),
    .free_idx_o (free_idx)
  );

  // scan keys: the packet sequence on arrival, else the expected sequence;
  // a start or resume rescans with the oldest buffered sequence
  always_comb begin
    if (state_q == ST_DECIDE) begin
      scan_key      = {1'b0, min_seq};
      scan_next_key = {1'b0, min_seq} + 33'd1;
    end else begin
      scan_key      = (in_i.opcode == OP_ARRIVAL) ? {1'b0, in_i.sequence_req}
                                                  : {1'b0, exp_q};
      scan_next_key = {1'b0, exp_q} + 33'd1;
    end
  end

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE:   if (in_valid_i) state_d = ST_SCAN;
      ST_SCAN:   if (flags.done) state_d = ST_DECIDE;
      ST_DECIDE: state_d = rescan ? ST_SCAN : ST_OUT;
      ST_OUT:    if (!out_vld_q || out_ready_i) state_d = ST_IDLE;
      default:   state_d = ST_IDLE;
    endcase
  end

  // sequencer outputs
  always_comb begin
    in_ready_o = (state_q == ST_IDLE);
    scan_start = ((state_q == ST_IDLE) && in_valid_i) || ((state_q == ST_DECIDE) && rescan);
    res_load   = (state_q == ST_OUT) && (!out_vld_q || out_ready_i);
  end

  // decision logic, evaluated once per scan pass
  always_comb begin
    logic active, malformed, low, many, gap, hr, rb, can, do_play;
    logic [7:0] needed;

    used_d     = used_q;
    playing_d  = playing_q;
    rebuf_d    = rebuf_q;
    end_seen_d = end_seen_q;
    finished_d = finished_q;
    any_rx_d   = any_rx_q;
    exp_d      = exp_q;
    highest_d  = highest_q;
    final_d    = final_q;
    miss_d     = miss_q;
    last_arr_d = last_arr_q;
    res_d      = res_q;
    rescan     = 1'b0;
    wr_en      = 1'b0;
    do_play    = 1'b0;

    active    = playing_q && !rebuf_q;
    malformed = !req_q.payload_present || (req_q.payload_len == 16'd0) ||
                (req_q.payload_len > 16'(MAX_PAYLOAD)) ||
                (req_q.frame_samples != 16'(FRAME_LEN));
    needed    = playing_q ? resume_fill_q : start_fill_q;
    can       = (cnt != '0) && (end_seen_q || (CMW'(cnt) >= CMW'(needed)));
    low       = CMW'(cnt) <= CMW'(low_water_q);
    many      = (miss1_q >= {1'b0, miss_limit_q}) &&
                (CMW'(cnt) <= CMW'(resume_fill_q >> 1));
    gap       = (highest_q > old_exp_q) && ((highest_q - old_exp_q) > {16'd0, hard_gap_q});
    hr        = gap && (miss1_q >= {1'b0, hard_miss_q});
    rb        = !end_seen_q && (low || many || hr);

    if (state_q == ST_DECIDE) begin
      if (!pass_q) begin
        res_d = '0;
        res_d.status = STAT_WAITING;
        res_d.buffered_count = (CMW'(cnt) > CMW'(255)) ? 8'hFF : 8'(cnt);
      end
      unique case (req_q.opcode)
        OP_ARRIVAL: begin
          priority if (malformed) begin
            res_d.status = STAT_MALFORMED;
          end else if (flags.key_hit) begin
            res_d.status = STAT_DUPLICATE;
          end else if (active && (req_q.sequence_req < exp_q)) begin
            res_d.status = STAT_LATE;
          end else if (active && ({1'b0, req_q.sequence_req} >
                                  ({1'b0, exp_q} + {17'd0, ahead_q}))) begin
            res_d.status = STAT_BEYOND;
          end else if (!flags.free_hit) begin
            res_d.status = STAT_FULL;
          end else begin
            wr_en            = 1'b1;
            used_d[free_idx] = 1'b1;
            if (!any_rx_q || (req_q.sequence_req > highest_q)) begin
              highest_d = req_q.sequence_req;
            end
            any_rx_d         = 1'b1;
            last_arr_d       = req_q.now_ms;
            res_d.status     = STAT_INSERTED;
            res_d.slot_index = 7'(free_idx);
          end
        end
        OP_TICK: begin
          if (pass_q) begin
            do_play = 1'b1;
          end else begin
            priority if (finished_q) begin
              res_d.status = STAT_WAITING;
            end else if (end_seen_q && (cnt == '0) && (exp_q >= final_q)) begin
              playing_d = 1'b0; rebuf_d = 1'b1; finished_d = 1'b1; miss_d = '0;
              res_d.status = STAT_END_FIN;
            end else if (!end_seen_q && playing_q && (cnt == '0) &&
                         ((req_q.now_ms - last_arr_q) > {16'd0, idle_to_q})) begin
              playing_d = 1'b0; rebuf_d = 1'b1; finished_d = 1'b1; miss_d = '0;
              res_d.status = STAT_TIMEOUT;
            end else if (rebuf_q || !playing_q) begin
              if (can) begin
                // start from the oldest buffered packet, then look it up again
                exp_d = min_seq; playing_d = 1'b1; rebuf_d = 1'b0; miss_d = '0;
                rescan = 1'b1;
              end else begin
                res_d.status = STAT_WAITING;
              end
            end else begin
              do_play = 1'b1;
            end
          end
          if (do_play) begin
            if (flags.key_hit) begin
              used_d[key_idx]     = 1'b0;
              res_d.status        = STAT_PLAY;
              res_d.slot_index    = 7'(key_idx);
              res_d.play_sequence = exp_q;
              exp_d  = (exp_q == SEQ_MAX) ? exp_q : exp_q + 32'd1;
              miss_d = '0;
            end else begin
              miss_d = (miss_q == MISS_MAX) ? miss_q : miss_q + 8'd1;
              res_d.hard_rebuffer = hr;
              if (rb) begin
                rebuf_d      = 1'b1;
                res_d.status = STAT_REBUFFER;
              end else begin
                res_d.status        = STAT_CONCEAL;
                res_d.play_sequence = exp_q;
                res_d.fec_present   = flags.next_hit;
                res_d.fec_slot      = flags.next_hit ? 7'(next_idx) : 7'd0;
                exp_d = (exp_q == SEQ_MAX) ? exp_q : exp_q + 32'd1;
              end
            end
          end
        end
        OP_END: begin
          end_seen_d   = 1'b1;
          final_d      = req_q.sequence_req;
          res_d.status = STAT_END_REC;
        end
        OP_RESET: begin
          used_d     = '0;
          playing_d  = 1'b0;
          rebuf_d    = 1'b1;
          end_seen_d = 1'b0;
          finished_d = 1'b0;
          any_rx_d   = 1'b0;
          exp_d      = '0;
          highest_d  = '0;
          final_d    = '0;
          miss_d     = '0;
          last_arr_d = '0;
          res_d.status = STAT_RESET;
        end
        default: res_d.status = STAT_WAITING;
      endcase
    end
  end

  // config writes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      start_fill_q  <= RST_START_FILL;
      resume_fill_q <= RST_RESUME_FILL;
      low_water_q   <= RST_LOW_WATER;
      miss_limit_q  <= RST_MISS_LIMIT;
      ahead_q       <= RST_AHEAD_WINDOW;
      hard_gap_q    <= RST_HARD_GAP;
      hard_miss_q   <= RST_HARD_MISS_LIMIT;
      idle_to_q     <= RST_IDLE_TIMEOUT;
    end else if (cfg_we_i) begin
      unique case (cfg_e'(cfg_idx_i))
        CFG_START_FILL:      start_fill_q  <= cfg_data_i[7:0];
        CFG_RESUME_FILL:     resume_fill_q <= cfg_data_i[7:0];
        CFG_LOW_WATER:       low_water_q   <= cfg_data_i[7:0];
        CFG_MISS_LIMIT:      miss_limit_q  <= cfg_data_i[7:0];
        CFG_AHEAD_WINDOW:    ahead_q       <= cfg_data_i;
        CFG_HARD_GAP:        hard_gap_q    <= cfg_data_i;
        CFG_HARD_MISS_LIMIT: hard_miss_q   <= cfg_data_i[7:0];
        CFG_IDLE_TIMEOUT:    idle_to_q     <= cfg_data_i;
        default:             ;
      endcase
    end
  end

  // session state and sequencer
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= ST_IDLE;
      pass_q     <= 1'b0;
      used_q     <= '0;
      playing_q  <= 1'b0;
      rebuf_q    <= 1'b1;
      end_seen_q <= 1'b0;
      finished_q <= 1'b0;
      any_rx_q   <= 1'b0;
      exp_q      <= '0;
      highest_q  <= '0;
      final_q    <= '0;
      miss_q     <= '0;
      last_arr_q <= '0;
      out_vld_q  <= 1'b0;
    end else begin
      state_q    <= state_d;
      used_q     <= used_d;
      playing_q  <= playing_d;
      rebuf_q    <= rebuf_d;
      end_seen_q <= end_seen_d;
      finished_q <= finished_d;
      any_rx_q   <= any_rx_d;
      exp_q      <= exp_d;
      highest_q  <= highest_d;
      final_q    <= final_d;
      miss_q     <= miss_d;
      last_arr_q <= last_arr_d;
      if (accept) begin
        pass_q <= 1'b0;
      end else if ((state_q == ST_DECIDE) && rescan) begin
        pass_q <= 1'b1;
      end
      if (res_load) begin
        out_vld_q <= 1'b1;
      end else if (out_ready_i) begin
        out_vld_q <= 1'b0;
      end
    end
  end

  // request context and result payload
  always_ff @(posedge clk_i) begin
    if (accept) begin
      req_q     <= in_i;
      miss1_q   <= {1'b0, miss_q} + 9'd1;
      old_exp_q <= exp_q;
    end
    res_q <= res_d;
    if (res_load) begin
      out_q <= res_q;
    end
  end

  assign out_valid_o = out_vld_q;
  assign out_o       = out_q;

  // checks on the sequencer
  `PJBC_ASSERT_NEXT(a_busy_after_accept, accept, !in_ready_o, "ready after accept")
  `PJBC_ASSERT_NOW(a_write_in_decide, wr_en, (state_q == ST_DECIDE) && flags.free_hit,
    "slot write outside decide")
  `PJBC_ASSERT_NOW(a_result_from_out, $rose(out_valid_o), $past(state_q == ST_OUT),
    "result not from output state")

endmodule

`default_nettype wire
